/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Checked at every rising edge, reset included.
`define ASSERT_CLK_ANY(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

/* hw/rtl/ptlvr_pkg.sv */
// ----------------------------------------------------------------------------
// ptlvr_pkg
// Shared types and constants of the peer table with least-value replacement.
// ----------------------------------------------------------------------------
`default_nettype none

package ptlvr_pkg;

  localparam int CMD_W      = 2;
  localparam int ID_W       = 32;
  localparam int STATUS_W   = 2;
  localparam int MEMBERS_W  = 7;
  localparam int TICKS_W    = 32;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_INC    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_TICK   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_FAIL     = 2'd0,
    ST_INSERTED = 2'd1,
    ST_REPLACED = 2'd2,
    ST_ACK      = 2'd3
  } status_t;

  localparam logic [CFG_ADDR_W-1:0] REG_MAX_MEMBERS  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_STASIS_TICKS = 2'd1;

  localparam logic [MEMBERS_W-1:0] MAX_MEMBERS_RST  = 7'd8;
  localparam logic [TICKS_W-1:0]   STASIS_TICKS_RST = 32'd60;

  // what the slot walk found
  typedef struct packed {
    logic hit;     // key present in a valid slot
    logic free;    // some slot is empty
    logic worst;   // some valid slot exists
  } scan_flags_t;

endpackage

`default_nettype wire

/* hw/rtl/ptlvr_channels.sv */
// ----------------------------------------------------------------------------
// ptlvr_channels
// Valid/ready channel interfaces for commands, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface ptlvr_in_if;
  logic                         valid;
  logic                         ready;
  logic [ptlvr_pkg::CMD_W-1:0]  cmd;
  logic [ptlvr_pkg::ID_W-1:0]   peer_id;

  modport source (output valid, output cmd, output peer_id, input ready);
  modport sink   (input valid, input cmd, input peer_id, output ready);
endinterface

interface ptlvr_out_if;
  logic                           valid;
  logic                           ready;
  logic [ptlvr_pkg::STATUS_W-1:0] status;
  logic [ptlvr_pkg::ID_W-1:0]     evicted_id;

  modport source (output valid, output status, output evicted_id, input ready);
  modport sink   (input valid, input status, input evicted_id, output ready);
endinterface

interface ptlvr_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [ptlvr_pkg::CFG_ADDR_W-1:0] index;
  logic [ptlvr_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/ptlvr_scan.sv */
// ----------------------------------------------------------------------------
// ptlvr_scan
// Accumulates key match, first free slot and lowest-scored slot while the
// slot memory is walked one entry per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ptlvr_scan #(
  parameter int TABLE_DEPTH = 8,
  parameter int SCORE_BITS  = 16,
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          eval,
  input  logic [IDX_W-1:0]              eval_idx,
  input  logic                          slot_on,
  input  logic [ptlvr_pkg::ID_W-1:0]    slot_id,
  input  logic [SCORE_BITS-1:0]         slot_score,
  input  logic [ptlvr_pkg::ID_W-1:0]    key_id,
  output ptlvr_pkg::scan_flags_t        flags,
  output logic [IDX_W-1:0]              hit_idx,
  output logic [SCORE_BITS-1:0]         hit_score,
  output logic [IDX_W-1:0]              free_idx,
  output logic [IDX_W-1:0]              worst_idx,
  output logic [ptlvr_pkg::ID_W-1:0]    worst_id
);

  ptlvr_pkg::scan_flags_t        flags_r, flags_nxt;
  logic [IDX_W-1:0]              hit_idx_r, hit_idx_nxt;
  logic [SCORE_BITS-1:0]         hit_score_r, hit_score_nxt;
  logic [IDX_W-1:0]              free_idx_r, free_idx_nxt;
  logic [IDX_W-1:0]              worst_idx_r, worst_idx_nxt;
  logic [ptlvr_pkg::ID_W-1:0]    worst_id_r, worst_id_nxt;
  logic [SCORE_BITS-1:0]         worst_score_r, worst_score_nxt;
  logic                          take_worst;

  // lower score wins; equal score goes to the higher id
  assign take_worst = !flags_r.worst || (slot_score < worst_score_r) ||
                      ((slot_score == worst_score_r) && (slot_id > worst_id_r));

  always_comb begin
    flags_nxt       = flags_r;
    hit_idx_nxt     = hit_idx_r;
    hit_score_nxt   = hit_score_r;
    free_idx_nxt    = free_idx_r;
    worst_idx_nxt   = worst_idx_r;
    worst_id_nxt    = worst_id_r;
    worst_score_nxt = worst_score_r;
    if (start) begin
      flags_nxt = '0;
    end else if (eval) begin
      if (slot_on) begin
        if (slot_id == key_id) begin
          flags_nxt.hit = 1'b1;
          hit_idx_nxt   = eval_idx;
          hit_score_nxt = slot_score;
        end
        if (take_worst) begin
          flags_nxt.worst = 1'b1;
          worst_idx_nxt   = eval_idx;
          worst_id_nxt    = slot_id;
          worst_score_nxt = slot_score;
        end
      end else if (!flags_r.free) begin
        flags_nxt.free = 1'b1;
        free_idx_nxt   = eval_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else begin
      flags_r <= flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hit_idx_r     <= hit_idx_nxt;
    hit_score_r   <= hit_score_nxt;
    free_idx_r    <= free_idx_nxt;
    worst_idx_r   <= worst_idx_nxt;
    worst_id_r    <= worst_id_nxt;
    worst_score_r <= worst_score_nxt;
  end

  assign flags     = flags_r;
  assign hit_idx   = hit_idx_r;
  assign hit_score = hit_score_r;
  assign free_idx  = free_idx_r;
  assign worst_idx = worst_idx_r;
  assign worst_id  = worst_id_r;

endmodule

`default_nettype wire

/* hw/rtl/peer_table_least_value_replace.sv */
// ----------------------------------------------------------------------------
// peer_table_least_value_replace
// Table of peer ids with usefulness scores and least-value replacement.
//
// Each command beat (insert, score increment, remove, tick) passes through
// the scan, drain and exec states and back to idle before the next beat
// can be accepted: the single read port of the slot memory is walked one
// entry per cycle in scan, drain evaluates the last read, exec applies the
// update and loads the result register, and idle takes the next beat. The
// exec state holds while the previous result beat is still waiting.
// One result beat per command; the result register lets the next command
// be taken while a result is still waiting. Slot valid bits and
// score-valid bits are flip-flops, so reset needs no clearing pass and
// clearing all scores on a replacement is immediate.
// Register writes are always ready and must only come while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module peer_table_least_value_replace #(
  parameter int TABLE_DEPTH = 8,
  parameter int SCORE_BITS  = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  ptlvr_in_if.sink          in_bus,
  ptlvr_out_if.source       out_bus,
  ptlvr_cfg_if.sink         cfg_bus
);

  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int WORD_W = ptlvr_pkg::ID_W + SCORE_BITS;
  localparam logic [IDX_W-1:0]      LAST_IDX  = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [SCORE_BITS-1:0] SCORE_MAX = {SCORE_BITS{1'b1}};

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_EXEC  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [ptlvr_pkg::MEMBERS_W-1:0] max_members_r;
  logic [ptlvr_pkg::TICKS_W-1:0]   stasis_ticks_r;

  // table state
  logic [TABLE_DEPTH-1:0]          slot_on_r, slot_on_nxt;
  logic [TABLE_DEPTH-1:0]          score_ok_r, score_ok_nxt;
  logic [CNT_W-1:0]                member_count_r, member_count_nxt;
  logic                            scoring_on_r, scoring_on_nxt;
  logic [ptlvr_pkg::TICKS_W-1:0]   wait_left_r, wait_left_nxt;

  logic [WORD_W-1:0]               mem [TABLE_DEPTH];
  logic [WORD_W-1:0]               rd_data_r;
  logic                            wr_en;
  logic [IDX_W-1:0]                wr_idx;
  logic [WORD_W-1:0]               wr_data;

  // current command
  ptlvr_pkg::cmd_t                 cmd_r;
  logic [ptlvr_pkg::ID_W-1:0]      key_r;

  logic [IDX_W-1:0]                rd_idx_r, rd_idx_nxt;
  logic                            eval_r;
  logic [IDX_W-1:0]                eval_idx_r;

  // result register
  logic                            out_valid_r, out_valid_nxt;
  ptlvr_pkg::status_t              status_r, status_nxt;
  logic [ptlvr_pkg::ID_W-1:0]      evicted_r, evicted_nxt;

  logic                            in_fire;
  logic                            out_free;
  logic [SCORE_BITS-1:0]           rd_score_eff;

  ptlvr_pkg::scan_flags_t          flags;
  logic [IDX_W-1:0]                hit_idx;
  logic [SCORE_BITS-1:0]           hit_score;
  logic [IDX_W-1:0]                free_idx;
  logic [IDX_W-1:0]                worst_idx;
  logic [ptlvr_pkg::ID_W-1:0]      worst_id;

  logic [CNT_W-1:0]                cap;
  logic [CNT_W-1:0]                count_inc;

  assign in_bus.ready  = (state_r == S_IDLE);
  assign cfg_bus.ready = 1'b1;
  assign in_fire       = in_bus.valid && in_bus.ready;
  assign out_free      = !out_valid_r || out_bus.ready;

  // capacity in use: zero acts as one, clipped to the table depth
  always_comb begin
    if (max_members_r == '0) begin
      cap = CNT_W'(1);
    end else if (max_members_r > ptlvr_pkg::MEMBERS_W'(TABLE_DEPTH)) begin
      cap = CNT_W'(TABLE_DEPTH);
    end else begin
      cap = max_members_r[CNT_W-1:0];
    end
  end

  assign count_inc = member_count_r + 1'b1;

  // score of a slot reads as zero after a table-wide clear
  assign rd_score_eff = score_ok_r[eval_idx_r] ? rd_data_r[SCORE_BITS-1:0] : '0;

  ptlvr_scan #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .SCORE_BITS  (SCORE_BITS)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (in_fire),
    .eval       (eval_r),
    .eval_idx   (eval_idx_r),
    .slot_on    (slot_on_r[eval_idx_r]),
    .slot_id    (rd_data_r[WORD_W-1:SCORE_BITS]),
    .slot_score (rd_score_eff),
    .key_id     (key_r),
    .flags      (flags),
    .hit_idx    (hit_idx),
    .hit_score  (hit_score),
    .free_idx   (free_idx),
    .worst_idx  (worst_idx),
    .worst_id   (worst_id)
  );

  always_comb begin
    state_nxt        = state_r;
    rd_idx_nxt       = rd_idx_r;
    slot_on_nxt      = slot_on_r;
    score_ok_nxt     = score_ok_r;
    member_count_nxt = member_count_r;
    scoring_on_nxt   = scoring_on_r;
    wait_left_nxt    = wait_left_r;
    out_valid_nxt    = out_valid_r && !out_bus.ready;
    status_nxt       = status_r;
    evicted_nxt      = evicted_r;
    wr_en            = 1'b0;
    wr_idx           = '0;
    wr_data          = {key_r, {SCORE_BITS{1'b0}}};

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          rd_idx_nxt = '0;
          state_nxt  = S_SCAN;
        end
      end
      S_SCAN: begin
        if (rd_idx_r == LAST_IDX) begin
          state_nxt = S_DRAIN;
        end else begin
          rd_idx_nxt = rd_idx_r + 1'b1;
        end
      end
      S_DRAIN: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          status_nxt    = ptlvr_pkg::ST_ACK;
          evicted_nxt   = '0;
          case (cmd_r)
            ptlvr_pkg::CMD_INSERT: begin
              status_nxt = ptlvr_pkg::ST_FAIL;
              if (!flags.hit) begin
                if (member_count_r < cap) begin
                  if (flags.free) begin
                    wr_en                  = 1'b1;
                    wr_idx                 = free_idx;
                    slot_on_nxt[free_idx]  = 1'b1;
                    score_ok_nxt[free_idx] = 1'b1;
                    member_count_nxt       = count_inc;
                    if (count_inc >= cap) begin
                      scoring_on_nxt = 1'b1;
                      wait_left_nxt  = stasis_ticks_r;
                    end
                    status_nxt = ptlvr_pkg::ST_INSERTED;
                  end
                end else if (wait_left_r == '0 && flags.worst) begin
                  wr_en                   = 1'b1;
                  wr_idx                  = worst_idx;
                  score_ok_nxt            = '0;
                  score_ok_nxt[worst_idx] = 1'b1;
                  wait_left_nxt           = stasis_ticks_r;
                  status_nxt              = ptlvr_pkg::ST_REPLACED;
                  evicted_nxt             = worst_id;
                end
              end
            end
            ptlvr_pkg::CMD_INC: begin
              if (scoring_on_r && flags.hit && hit_score != SCORE_MAX) begin
                wr_en                 = 1'b1;
                wr_idx                = hit_idx;
                wr_data               = {key_r, hit_score + 1'b1};
                score_ok_nxt[hit_idx] = 1'b1;
              end
            end
            ptlvr_pkg::CMD_REMOVE: begin
              if (flags.hit) begin
                slot_on_nxt[hit_idx] = 1'b0;
                if (member_count_r != '0) begin
                  member_count_nxt = member_count_r - 1'b1;
                end
              end
            end
            ptlvr_pkg::CMD_TICK: begin
              if (wait_left_r != '0) begin
                wait_left_nxt = wait_left_r - 1'b1;
              end
            end
            default: begin
              status_nxt = ptlvr_pkg::ST_ACK;
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      slot_on_r      <= '0;
      score_ok_r     <= '0;
      member_count_r <= '0;
      scoring_on_r   <= 1'b0;
      wait_left_r    <= '0;
      out_valid_r    <= 1'b0;
      eval_r         <= 1'b0;
      max_members_r  <= ptlvr_pkg::MAX_MEMBERS_RST;
      stasis_ticks_r <= ptlvr_pkg::STASIS_TICKS_RST;
    end else begin
      state_r        <= state_nxt;
      slot_on_r      <= slot_on_nxt;
      score_ok_r     <= score_ok_nxt;
      member_count_r <= member_count_nxt;
      scoring_on_r   <= scoring_on_nxt;
      wait_left_r    <= wait_left_nxt;
      out_valid_r    <= out_valid_nxt;
      eval_r         <= (state_r == S_SCAN);
      if (cfg_bus.valid && cfg_bus.ready) begin
        if (cfg_bus.index == ptlvr_pkg::REG_MAX_MEMBERS) begin
          max_members_r <= cfg_bus.data[ptlvr_pkg::MEMBERS_W-1:0];
        end else if (cfg_bus.index == ptlvr_pkg::REG_STASIS_TICKS) begin
          stasis_ticks_r <= cfg_bus.data[ptlvr_pkg::TICKS_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r   <= rd_idx_nxt;
    eval_idx_r <= rd_idx_r;
    status_r   <= status_nxt;
    evicted_r  <= evicted_nxt;
    if (in_fire) begin
      cmd_r <= ptlvr_pkg::cmd_t'(in_bus.cmd);
      key_r <= in_bus.peer_id;
    end
  end

  // slot memory: id in the upper bits, score below
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    rd_data_r <= mem[rd_idx_r];
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.status     = status_r;
  assign out_bus.evicted_id = evicted_r;

endmodule

`default_nettype wire

/* hw/rtl/ptlvr_checker.sv */
// ----------------------------------------------------------------------------
// ptlvr_checker
// Port-level checks of the peer table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ptlvr_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [ptlvr_pkg::STATUS_W-1:0] out_status,
  input  logic [ptlvr_pkg::ID_W-1:0]     out_evicted_id
);

  // one command at a time: busy right after a command beat
  `ASSERT_CLK(a_busy_after_cmd, clk, rst_n, (in_valid && in_ready) |=> !in_ready)

  // no new result in the cycle after a command beat (the walk is pending)
  `ASSERT_CLK(a_no_early_result, clk, rst_n,
    (in_valid && in_ready && !(out_valid && !out_ready)) |=> !out_valid)

  // evicted id is zero unless a replacement is reported
  `ASSERT_CLK(a_evicted_only_on_replace, clk, rst_n,
    (out_valid && out_status != ptlvr_pkg::ST_REPLACED) |-> (out_evicted_id == '0))

  // a stalled result holds
  `ASSERT_CLK(a_out_hold, clk, rst_n,
    (out_valid && !out_ready) |=> (out_valid && $stable(out_status)))

  // reset empties the result register
  `ASSERT_CLK_ANY(a_reset_clears_out, clk, !rst_n |=> !out_valid)

endmodule

bind peer_table_least_value_replace ptlvr_checker u_ptlvr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_bus.valid),
  .in_ready       (in_bus.ready),
  .out_valid      (out_bus.valid),
  .out_ready      (out_bus.ready),
  .out_status     (out_bus.status),
  .out_evicted_id (out_bus.evicted_id)
);

`default_nettype wire
